/* design/lpd_pkg.sv */
// Shared types, codes and constants of the line and payload deframer.
// Used by lpd_ctrl and line_and_payload_deframer_unit; depends on nothing.
package lpd_pkg;

	// Default parameter values
	localparam int LINE_CAP_DEF    = 64;
	localparam int LENGTH_BITS_DEF = 24;

	// Fixed field widths
	localparam int KIND_W     = 2;
	localparam int OUT_KIND_W = 3;
	localparam int BYTE_W     = 8;
	localparam int PLEN_W     = 24;

	// Input kind codes
	localparam logic [KIND_W-1:0] KIND_BYTE       = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BEGIN      = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DISCONNECT = 2'd2;

	// Result kind codes
	localparam logic [OUT_KIND_W-1:0] OUT_LINE       = 3'd0;
	localparam logic [OUT_KIND_W-1:0] OUT_PAYLOAD    = 3'd1;
	localparam logic [OUT_KIND_W-1:0] OUT_ACCEPTED   = 3'd2;
	localparam logic [OUT_KIND_W-1:0] OUT_WRONG_MODE = 3'd3;
	localparam logic [OUT_KIND_W-1:0] OUT_ZERO_LEN   = 3'd4;
	localparam logic [OUT_KIND_W-1:0] OUT_ABORTED    = 3'd5;

	// Character codes
	localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

	// One result word
	typedef struct packed {
		logic [OUT_KIND_W-1:0] kind;
		logic [BYTE_W-1:0]     data;
		logic                  last;
	} result_t;

endpackage

/* design/lpd_line_ram.sv */
// Line buffer memory: one write port, one read port with registered data.
// Depends on nothing; instantiated by lpd_ctrl.
module lpd_line_ram #(
	parameter int DEPTH  = 63,
	parameter int ADDR_W = 6
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* design/lpd_ctrl.sv */
// Deframer sequencer: mode and length state, line buffer writes and readout,
// result register. Depends on lpd_pkg and lpd_line_ram.
module lpd_ctrl #(
	parameter int LINE_CAP    = lpd_pkg::LINE_CAP_DEF,
	parameter int LENGTH_BITS = lpd_pkg::LENGTH_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         deliver_payloads,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [lpd_pkg::KIND_W-1:0]   kind,
	input  logic [lpd_pkg::BYTE_W-1:0]   in_byte,
	input  logic [lpd_pkg::PLEN_W-1:0]   payload_length,
	output logic                         out_valid,
	input  logic                         out_ready,
	output lpd_pkg::result_t             result
);

	localparam int DEPTH  = LINE_CAP - 1;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LEN_W  = $clog2(LINE_CAP);
	localparam int REM_W  = (LENGTH_BITS < lpd_pkg::PLEN_W) ? LENGTH_BITS : lpd_pkg::PLEN_W;

	typedef enum logic {
		S_IDLE,
		S_FLUSH
	} state_t;

	state_t                state_q, state_d;
	logic                  payload_mode_q, payload_mode_d;
	logic [LEN_W-1:0]      line_len_q, line_len_d;
	logic [REM_W-1:0]      remaining_q, remaining_d;
	logic [ADDR_W-1:0]     rd_idx_q, rd_idx_d;
	logic [ADDR_W-1:0]     flush_last_q, flush_last_d;
	logic                  out_valid_q, out_valid_d;
	lpd_pkg::result_t      result_q, result_d;

	logic                  slot_free;
	logic                  accept;
	logic                  wr_en;
	logic                  rd_en;
	logic [ADDR_W-1:0]     rd_addr;
	logic [7:0]            rd_data;
	logic [REM_W-1:0]      len_in;
	logic [REM_W-1:0]      rem_dec;

	lpd_line_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (line_len_q[ADDR_W-1:0]),
		.wr_data (in_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;
	assign len_in    = payload_length[REM_W-1:0];
	assign rem_dec   = (remaining_q != '0) ? remaining_q - REM_W'(1) : remaining_q;

	// Decode the accepted word and step the line readout
	always_comb begin
		state_d        = state_q;
		payload_mode_d = payload_mode_q;
		line_len_d     = line_len_q;
		remaining_d    = remaining_q;
		rd_idx_d       = rd_idx_q;
		flush_last_d   = flush_last_q;
		out_valid_d    = out_valid_q && !out_ready;
		result_d       = result_q;
		wr_en          = 1'b0;
		rd_en          = 1'b0;
		rd_addr        = '0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (kind)
						lpd_pkg::KIND_DISCONNECT: begin
							line_len_d = '0;
							if (payload_mode_q) begin
								payload_mode_d = 1'b0;
								remaining_d    = '0;
								out_valid_d    = 1'b1;
								result_d       = '{lpd_pkg::OUT_ABORTED, '0, 1'b0};
							end
						end
						lpd_pkg::KIND_BEGIN: begin
							out_valid_d = 1'b1;
							if (payload_mode_q) begin
								result_d = '{lpd_pkg::OUT_WRONG_MODE, '0, 1'b0};
							end else if (len_in == '0) begin
								result_d = '{lpd_pkg::OUT_ZERO_LEN, '0, 1'b0};
							end else begin
								payload_mode_d = 1'b1;
								remaining_d    = len_in;
								result_d       = '{lpd_pkg::OUT_ACCEPTED, '0, 1'b0};
							end
						end
						lpd_pkg::KIND_BYTE: begin
							if (payload_mode_q) begin
								// Count the payload down; if delivery is on, pass it through, NUL becomes space
								remaining_d = rem_dec;
								if (rem_dec == '0) begin
									payload_mode_d = 1'b0;
								end
								if (deliver_payloads) begin
									out_valid_d   = 1'b1;
									result_d.kind = lpd_pkg::OUT_PAYLOAD;
									result_d.data = (in_byte == lpd_pkg::CHAR_NUL) ?
										lpd_pkg::CHAR_SPACE : in_byte;
									result_d.last = (rem_dec == '0);
								end
							end else if (in_byte == lpd_pkg::CHAR_LF) begin
								// Start readout of a nonempty line at entry zero
								line_len_d = '0;
								if (line_len_q != '0) begin
									flush_last_d = ADDR_W'(line_len_q - LEN_W'(1));
									rd_idx_d     = '0;
									rd_en        = 1'b1;
									state_d      = S_FLUSH;
								end
							end else if (in_byte != lpd_pkg::CHAR_CR) begin
								// Buffer the byte, or drop the whole line on overflow
								if (line_len_q < LEN_W'(DEPTH)) begin
									wr_en      = 1'b1;
									line_len_d = line_len_q + LEN_W'(1);
								end else begin
									line_len_d = '0;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_FLUSH: begin
				// Move one stored byte out per free slot, prefetch the next
				if (slot_free) begin
					out_valid_d   = 1'b1;
					result_d.kind = lpd_pkg::OUT_LINE;
					result_d.data = rd_data;
					result_d.last = (rd_idx_q == flush_last_q);
					if (rd_idx_q == flush_last_q) begin
						state_d = S_IDLE;
					end else begin
						rd_idx_d = rd_idx_q + ADDR_W'(1);
						rd_en    = 1'b1;
						rd_addr  = rd_idx_d;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			payload_mode_q <= 1'b0;
			line_len_q     <= '0;
			remaining_q    <= '0;
			rd_idx_q       <= '0;
			flush_last_q   <= '0;
			out_valid_q    <= 1'b0;
			result_q       <= '0;
		end else begin
			state_q        <= state_d;
			payload_mode_q <= payload_mode_d;
			line_len_q     <= line_len_d;
			remaining_q    <= remaining_d;
			rd_idx_q       <= rd_idx_d;
			flush_last_q   <= flush_last_d;
			out_valid_q    <= out_valid_d;
			result_q       <= result_d;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

/* design/line_and_payload_deframer_unit.sv */
// Line and payload deframer top level: configuration register and ports.
// Depends on lpd_pkg and lpd_ctrl.
//
// Input words (kind, in_byte, payload_length) enter on in_valid/in_ready;
// results (out_kind, out_byte, out_last) leave on out_valid/out_ready from
// a single output register. The deliver_payloads bit is written through
// cfg_valid/cfg_ready/cfg_data, which is always ready.
// A word that yields a result shows it on the outputs in the cycle after it
// is accepted, and a new word is taken in that same cycle if the result is
// consumed, so outside a line readout the block sustains one word per cycle.
// An LF that closes a nonempty line blocks the input while the bytes are
// read back from the line memory (one read per cycle while the output is not
// stalled, read data registered in the memory); the line bytes then leave the
// result register one per cycle while out_ready is high.
// With a result pending and out_ready low, the result register holds and in_ready
// drops until it is taken; the line readout pauses without losing a byte.
// Reset puts the block in line mode with an empty line, no payload pending
// and deliver_payloads set; the line memory itself is not cleared.
module line_and_payload_deframer_unit #(
	parameter int LINE_CAP    = lpd_pkg::LINE_CAP_DEF,
	parameter int LENGTH_BITS = lpd_pkg::LENGTH_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [lpd_pkg::KIND_W-1:0]      kind,
	input  logic [lpd_pkg::BYTE_W-1:0]      in_byte,
	input  logic [lpd_pkg::PLEN_W-1:0]      payload_length,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [lpd_pkg::OUT_KIND_W-1:0]  out_kind,
	output logic [lpd_pkg::BYTE_W-1:0]      out_byte,
	output logic                            out_last
);

	logic             deliver_payloads_q;
	lpd_pkg::result_t result;

	// Hold the configuration bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deliver_payloads_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			deliver_payloads_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;

	lpd_ctrl #(
		.LINE_CAP    (LINE_CAP),
		.LENGTH_BITS (LENGTH_BITS)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.deliver_payloads (deliver_payloads_q),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.kind             (kind),
		.in_byte          (in_byte),
		.payload_length   (payload_length),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.result           (result)
	);

	assign out_kind = result.kind;
	assign out_byte = result.data;
	assign out_last = result.last;

endmodule
